FILE: hdl/sfrd_pkg.sv
// Package for the dual-header serial frame receiver.
// Holds the header codes, the queue sizing and the word types used across the modules.
// No dependencies.
`default_nettype none

package sfrd_pkg;

  // Header codes
  localparam logic [7:0] Sync0A = 8'hA5;
  localparam logic [7:0] Sync0B = 8'hAA;
  localparam logic [7:0] Sync1A = 8'h5A;
  localparam logic [7:0] Sync1B = 8'h55;
  localparam logic [7:0] CmdA   = 8'h04;
  localparam logic [7:0] CmdB   = 8'h40;
  localparam logic [7:0] CmdC   = 8'h41;

  // Word kinds
  localparam logic KindByte = 1'b0;
  localparam logic KindArm  = 1'b1;

  // Frame length limit after reset
  localparam logic [15:0] MaxLenRst = 16'd32;

  // Queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Classified input word
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] arm_length;
    logic        arm_zero;   // arm request with zero length
    logic        sync0_ok;
    logic        sync1_ok;
    logic        cmd_ok;
    logic        len_nz;     // byte is nonzero (length field)
  } cls_t;

  // Result word
  typedef struct packed {
    logic       write_enable;
    logic [7:0] write_index;
    logic [7:0] write_data;
    logic       frame_complete;
    logic       resync;
    logic       arm_error;
    logic       received_flag;
  } res_t;

  // Queue status
  typedef struct packed {
    logic             empty;
    logic             full;
    logic [QCntW-1:0] count;
  } qstat_t;

endpackage

`default_nettype wire

FILE: hdl/sfrd_ifs.sv
// Channel interfaces for the dual-header serial frame receiver.
// Input word, result word and configuration write channels; no dependencies.
`default_nettype none

interface sfrd_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [15:0] arm_length;

  modport source (output valid, kind, data_byte, arm_length, input ready);
  modport sink   (input valid, kind, data_byte, arm_length, output ready);
endinterface

interface sfrd_res_if;
  logic       valid;
  logic       ready;
  logic       write_enable;
  logic [7:0] write_index;
  logic [7:0] write_data;
  logic       frame_complete;
  logic       resync;
  logic       arm_error;
  logic       received_flag;

  modport source (output valid, write_enable, write_index, write_data, frame_complete,
                  resync, arm_error, received_flag, input ready);
  modport sink   (input valid, write_enable, write_index, write_data, frame_complete,
                  resync, arm_error, received_flag, output ready);
endinterface

interface sfrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/serial_frame_receiver_dual_header_top.sv
// Top level of the dual-header serial frame receiver.
// Depends on sfrd_pkg, the channel interfaces, sfrd_front, sfrd_queue and sfrd_back.
`default_nettype none

// Takes received bytes and arm requests, one word per cycle while the queue is not
// full, and returns exactly one result word for each: a buffer write for every
// accepted header, payload or checksum byte, a resync flag on a failed check, an arm
// error for a zero-length arm, and the frame-held level. A result passes through a
// queue slot, then the result register; the sustained rate is one word per cycle
// while the output is not stalled. The two-entry queue lets input and output stall
// independently. max_frame_len must be written through the cfg channel (always ready)
// only while no word is in flight; the block does not enforce this. It resets to 32.
module serial_frame_receiver_dual_header_top (
  input  logic        clk,
  input  logic        rst_n,
  sfrd_in_if.sink     in_if,
  sfrd_res_if.source  out_if,
  sfrd_cfg_if.sink    cfg_if
);
  import sfrd_pkg::*;

  cls_t   push_data, head;
  logic   push_valid, push_ready;
  logic   head_valid, pop;
  qstat_t q_stat;

  sfrd_front u_front (
    .in_if      (in_if),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  sfrd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (head),
    .pop_valid  (head_valid),
    .pop_req    (pop),
    .stat       (q_stat)
  );

  sfrd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_if     (out_if),
    .cfg_if     (cfg_if)
  );

`ifndef SYNTHESIS
  // Queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCntW'(QDepth))
    else $error("queue count beyond depth");

  // An arm error carries no write, resync or frame completion
  a_arm_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.arm_error |->
      !out_if.write_enable && !out_if.resync && !out_if.frame_complete)
    else $error("arm error mixed with byte result");

  // A completed frame is written and flagged as held
  a_complete_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.frame_complete |-> out_if.write_enable && out_if.received_flag)
    else $error("frame complete without write or held flag");

  // A rejected byte is never written
  a_resync_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.resync |-> !out_if.write_enable)
    else $error("resync with write");

  // Accepted input reaches the queue in the next cycle
  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !q_stat.empty)
    else $error("accepted word lost before queue");
`endif

endmodule

`default_nettype wire

FILE: hdl/sfrd_front.sv
// Front end: accepts input words and classifies the header checks that need no state.
// Depends on sfrd_pkg and sfrd_in_if.
`default_nettype none

module sfrd_front (
  sfrd_in_if.sink         in_if,
  output sfrd_pkg::cls_t  push_data,
  output logic            push_valid,
  input  logic            push_ready
);
  import sfrd_pkg::*;

  // Handshake passes straight to the queue
  assign push_valid  = in_if.valid;
  assign in_if.ready = push_ready;

  // Stateless classification of the word
  always_comb begin
    push_data.kind       = in_if.kind;
    push_data.data_byte  = in_if.data_byte;
    push_data.arm_length = in_if.arm_length;
    push_data.arm_zero   = (in_if.arm_length == 16'd0);
    push_data.sync0_ok   = (in_if.data_byte == Sync0A) || (in_if.data_byte == Sync0B);
    push_data.sync1_ok   = (in_if.data_byte == Sync1A) || (in_if.data_byte == Sync1B);
    push_data.cmd_ok     = (in_if.data_byte == CmdA) || (in_if.data_byte == CmdB) ||
                           (in_if.data_byte == CmdC);
    push_data.len_nz     = (in_if.data_byte != 8'd0);
  end

endmodule

`default_nettype wire

FILE: hdl/sfrd_queue.sv
// Short FIFO of classified words between the front and back ends.
// Depends on sfrd_pkg.
`default_nettype none

module sfrd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  sfrd_pkg::cls_t   push_data,
  input  logic             push_valid,
  output logic             push_ready,
  output sfrd_pkg::cls_t   pop_data,
  output logic             pop_valid,
  input  logic             pop_req,
  output sfrd_pkg::qstat_t stat
);
  import sfrd_pkg::*;

  cls_t             mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] cnt_r;
  logic             push, pop;

  assign stat.empty = (cnt_r == QCntW'(0));
  assign stat.full  = (cnt_r == QCntW'(QDepth));
  assign stat.count = cnt_r;

  assign push_ready = !stat.full;
  assign pop_valid  = !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  assign push = push_valid && push_ready;
  assign pop  = pop_req && pop_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sfrd_back.sv
// Back end: frame parser state, the per-word step and the result register.
// Depends on sfrd_pkg, sfrd_res_if and sfrd_cfg_if.
`default_nettype none

module sfrd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  sfrd_pkg::cls_t  head,
  input  logic            head_valid,
  output logic            pop,
  sfrd_res_if.source      out_if,
  sfrd_cfg_if.sink        cfg_if
);
  import sfrd_pkg::*;

  logic [15:0] max_len_r;
  logic [15:0] count_r, count_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        en_r, en_nxt;
  logic        done_r, done_nxt;
  logic        out_valid_r;
  res_t        res_r, res_nxt;

  logic        active, ok, resync_req;
  logic [7:0]  sum_add;

  // Configuration register, always ready
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MaxLenRst;
    end else if (cfg_if.valid) begin
      max_len_r <= cfg_if.data;
    end
  end

  // Take a word when the result register is free or being drained
  assign pop = head_valid && (!out_valid_r || out_if.ready);

  assign active  = (head.kind == KindByte) && en_r && (len_r > count_r);
  assign sum_add = sum_r + head.data_byte;

  // One parser step
  always_comb begin
    count_nxt  = count_r;
    len_nxt    = len_r;
    sum_nxt    = sum_r;
    en_nxt     = en_r;
    done_nxt   = done_r;
    res_nxt    = '0;
    ok         = 1'b0;
    resync_req = 1'b0;

    if (head.kind == KindArm) begin
      if (head.arm_zero) begin
        res_nxt.arm_error = 1'b1;
      end else begin
        done_nxt  = 1'b0;
        count_nxt = 16'd0;
        len_nxt   = head.arm_length;
        en_nxt    = 1'b1;
      end
    end else if (active) begin
      priority if (count_r == 16'd0) begin
        ok = head.sync0_ok;
        if (ok) sum_nxt = head.data_byte;
      end else if (count_r == 16'd1) begin
        ok = head.sync1_ok;
        if (ok) sum_nxt = sum_add;
      end else if (count_r == 16'd2) begin
        ok = head.cmd_ok;
        if (ok) sum_nxt = sum_add;
      end else if (count_r == 16'd3) begin
        ok = head.len_nz && ({8'd0, head.data_byte} < len_r);
        if (ok) begin
          len_nxt = {8'd0, head.data_byte};
          sum_nxt = sum_add;
        end
      end else if (count_r == len_r - 16'd1) begin
        // checksum position: no count advance on success
        if (sum_r == head.data_byte) begin
          res_nxt.write_enable   = 1'b1;
          res_nxt.write_index    = count_r[7:0];
          res_nxt.write_data     = head.data_byte;
          res_nxt.frame_complete = 1'b1;
          en_nxt                 = 1'b0;
          done_nxt               = 1'b1;
        end else begin
          resync_req = 1'b1;
        end
      end else begin
        ok      = 1'b1;
        sum_nxt = sum_add;
      end

      // Header and payload bytes
      if (count_r != len_r - 16'd1 || count_r < 16'd4) begin
        if (ok) begin
          res_nxt.write_enable = 1'b1;
          res_nxt.write_index  = count_r[7:0];
          res_nxt.write_data   = head.data_byte;
          count_nxt            = count_r + 16'd1;
        end else begin
          resync_req = 1'b1;
        end
      end

      if (resync_req) begin
        res_nxt.resync = 1'b1;
        count_nxt      = 16'd0;
        sum_nxt        = 8'd0;
        len_nxt        = max_len_r;
      end
    end

    res_nxt.received_flag = done_nxt;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      en_r    <= 1'b0;
      done_r  <= 1'b0;
    end else if (pop) begin
      count_r <= count_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      en_r    <= en_nxt;
      done_r  <= done_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.write_enable   = res_r.write_enable;
  assign out_if.write_index    = res_r.write_index;
  assign out_if.write_data     = res_r.write_data;
  assign out_if.frame_complete = res_r.frame_complete;
  assign out_if.resync         = res_r.resync;
  assign out_if.arm_error      = res_r.arm_error;
  assign out_if.received_flag  = res_r.received_flag;

endmodule

`default_nettype wire
